>>> rtl/sm3_pkg.sv
// SM3 hash engine package: controller states, command/status structs and round functions.
// Used by every module of the hash engine; depends on nothing.
package sm3_pkg;

  localparam logic [255:0] SM3_IV = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_PAD,
    ST_PAD_FINAL,
    ST_OUTPUT
  } sm3_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       write_byte;   // store the accepted byte and count it
    logic       start;        // load window and working registers
    logic       round;        // run one compression round
    logic       finish;       // fold the working registers into the chaining value
    logic       pad_first;    // build padding block (0x80, zeros, maybe length)
    logic       pad_final;    // build length-only final block
    logic       reset_msg;    // restore the initial value and clear the count
  } sm3_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       block_full;   // the byte position is 63, so a write fills the block
    logic       last_round;   // round counter is at 63
    logic       two_blocks;   // padding spills into an extra block
  } sm3_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

>>> rtl/sm3_hash_engine.sv
// SM3 hash engine top level: joins the controller and the datapath.
// Depends on sm3_pkg, sm3_ctrl and sm3_dp.
//
//   Channel   Direction  Payload                                  Handshake
//   in_       request    data_byte, byte_valid, last              in_valid / in_stall
//   out_      result     digest_word, word_index, last_word       out_valid / out_stall
//
// A byte that does not complete a block is taken while in_stall is low. The byte that
// fills a block starts a compression, one round per cycle in the shared round unit,
// during which in_stall is high. A last request then builds the padding block and
// compresses it, and a length-only block too when the padding spills over, then eight
// digest words go out, one per cycle when out_stall is low. Reset is synchronous and
// active low and restores the initial value; no clearing pass is needed.
module sm3_hash_engine import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sm3_cmd_t  cmd;
  sm3_stat_t stat;

  sm3_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_valid  (in_byte_valid),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .cmd            (cmd),
    .stat           (stat)
  );

  sm3_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .word_sel        (out_word_index),
    .out_digest_word (out_digest_word),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

>>> rtl/sm3_ctrl.sv
// SM3 controller: sequences byte intake, compression rounds, padding and digest output.
// Depends on sm3_pkg.
module sm3_ctrl import sm3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_byte_valid,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_word_index,
  output logic       out_last_word,
  output sm3_cmd_t   cmd,
  input  sm3_stat_t  stat
);

  sm3_state_t state_r, state_nxt;
  logic       pend_last_r, pend_last_nxt;   // padding still owed after this block
  logic       pad_more_r, pad_more_nxt;     // a length-only block follows
  logic [2:0] word_r, word_nxt;
  logic       acc, out_acc;

  assign acc     = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Next state.
  always_comb begin
    state_nxt     = state_r;
    pend_last_nxt = pend_last_r;
    pad_more_nxt  = pad_more_r;
    word_nxt      = word_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_byte_valid && stat.block_full) begin
            state_nxt     = ST_COMPRESS;
            pend_last_nxt = in_last;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_COMPRESS: begin
        if (stat.last_round) begin
          if (pend_last_r) begin
            state_nxt     = ST_PAD;
            pend_last_nxt = 1'b0;
          end else if (pad_more_r) begin
            state_nxt    = ST_PAD_FINAL;
            pad_more_nxt = 1'b0;
          end else if (pad_more_r == 1'b0 && word_r == 3'd0 && pend_last_r == 1'b0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        state_nxt    = ST_COMPRESS;
        pad_more_nxt = stat.two_blocks;
        word_nxt     = stat.two_blocks ? 3'd0 : 3'd1;
      end
      ST_PAD_FINAL: begin
        state_nxt = ST_COMPRESS;
        word_nxt  = 3'd1;
      end
      ST_OUTPUT: begin
        if (out_acc) begin
          word_nxt = word_r + 3'd1;
          if (word_r == 3'd7) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // Final compression done: go to output starting at word 0.
    if (state_r == ST_COMPRESS && stat.last_round && !pend_last_r && !pad_more_r &&
        word_r == 3'd1) begin
      state_nxt = ST_OUTPUT;
      word_nxt  = 3'd0;
    end
  end

  // Outputs.
  always_comb begin
    cmd            = '0;
    in_stall       = (state_r != ST_IDLE);
    out_valid      = (state_r == ST_OUTPUT);
    out_word_index = word_r;
    out_last_word  = (word_r == 3'd7);
    case (state_r)
      ST_IDLE: begin
        cmd.write_byte = acc && in_byte_valid;
        cmd.start      = acc && in_byte_valid && stat.block_full;
      end
      ST_COMPRESS: begin
        cmd.round  = 1'b1;
        cmd.finish = stat.last_round;
      end
      ST_PAD:       cmd.pad_first = 1'b1;
      ST_PAD_FINAL: cmd.pad_final = 1'b1;
      ST_OUTPUT:    cmd.reset_msg = out_acc && (word_r == 3'd7);
      default: ;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_last_r <= 1'b0;
      pad_more_r  <= 1'b0;
      word_r      <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      pend_last_r <= pend_last_nxt;
      pad_more_r  <= pad_more_nxt;
      word_r      <= word_nxt;
    end
  end

endmodule

>>> rtl/sm3_dp.sv
// SM3 datapath: block buffer, bit counter, expansion window, round logic, chaining value.
// Depends on sm3_pkg.
module sm3_dp import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  logic [2:0]  word_sel,
  output logic [31:0] out_digest_word,
  input  sm3_cmd_t    cmd,
  output sm3_stat_t   stat
);

  logic [511:0] buf_r, buf_nxt;
  logic [63:0]  cnt_r, cnt_nxt;
  logic [31:0]  cv_r [8];
  logic [31:0]  w_r  [16];
  logic [31:0]  v_r  [8];
  logic [5:0]   rnd_r;
  logic [5:0]   pos;
  logic [511:0] pad_blk;
  logic [31:0]  wj, ahead, wnew, tj, ff, gg, a12, ss1, ss2, tt1, tt2;
  logic [3:0]   j4;

  assign pos = cnt_r[8:3];

  assign stat.block_full = (pos == 6'd63);
  assign stat.last_round = (rnd_r == 6'd63);
  assign stat.two_blocks = (pos > 6'd55);

  // Buffer write by byte position (byte 0 is the most significant).
  always_comb begin
    buf_nxt = buf_r;
    if (cmd.write_byte) begin
      buf_nxt[{~pos, 3'b000} +: 8] = in_data_byte;
    end
    cnt_nxt = cnt_r + (cmd.write_byte ? 64'd8 : 64'd0);
  end

  // Padding block: bytes before pos kept, 0x80 at pos, zeros, optional length.
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      if (b < pos) begin
        pad_blk[(63 - b) * 8 +: 8] = buf_r[(63 - b) * 8 +: 8];
      end else if (b == pos) begin
        pad_blk[(63 - b) * 8 +: 8] = PAD_BYTE;
      end else begin
        pad_blk[(63 - b) * 8 +: 8] = 8'h00;
      end
    end
    if (pos <= 6'd55) begin
      pad_blk[63:0] = cnt_r;
    end
  end

  // Round logic with on-the-fly expansion.
  assign j4    = rnd_r[3:0] + 4'd4;
  assign wj    = w_r[rnd_r[3:0]];
  assign wnew  = perm1(w_r[j4] ^ w_r[rnd_r[3:0] + 4'd11] ^
                       rotl(w_r[rnd_r[3:0] + 4'd1], 5'd15)) ^
                 rotl(w_r[rnd_r[3:0] + 4'd7], 5'd7) ^ w_r[rnd_r[3:0] + 4'd14];
  assign ahead = (rnd_r >= 6'd12) ? wnew : w_r[j4];
  assign tj    = (rnd_r < 6'd16) ? rotl(T_LOW, rnd_r[4:0]) : rotl(T_HIGH, rnd_r[4:0]);
  assign ff    = (rnd_r < 6'd16) ? (v_r[0] ^ v_r[1] ^ v_r[2]) :
                 ((v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]));
  assign gg    = (rnd_r < 6'd16) ? (v_r[4] ^ v_r[5] ^ v_r[6]) :
                 ((v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]));
  assign a12   = rotl(v_r[0], 5'd12);
  assign ss1   = rotl(a12 + v_r[4] + tj, 5'd7);
  assign ss2   = ss1 ^ a12;
  assign tt1   = ff + v_r[3] + ss2 + (wj ^ ahead);
  assign tt2   = gg + v_r[7] + ss1 + wj;

  assign out_digest_word = cv_r[word_sel];

  // Block buffer and bit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.reset_msg) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (cmd.pad_first) begin
      buf_r <= pad_blk;
    end else if (cmd.pad_final) begin
      buf_r <= {448'd0, cnt_r};
    end else begin
      buf_r <= buf_nxt;
    end
  end

  // Window, working registers and round counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (cmd.start || cmd.pad_first || cmd.pad_final) begin
      rnd_r <= '0;
    end else if (cmd.round) begin
      rnd_r <= rnd_r + 6'd1;
    end
    if (cmd.start) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= buf_nxt[(15 - i) * 32 +: 32];
      end
    end else if (cmd.pad_first) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= pad_blk[(15 - i) * 32 +: 32];
      end
    end else if (cmd.pad_final) begin
      for (int i = 0; i < 14; i++) begin
        w_r[i] <= 32'd0;
      end
      w_r[14] <= cnt_r[63:32];
      w_r[15] <= cnt_r[31:0];
    end else if (cmd.round && rnd_r >= 6'd12) begin
      w_r[j4] <= wnew;
    end
    if (cmd.start || cmd.pad_first || cmd.pad_final) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= cv_r[i];
      end
    end else if (cmd.round) begin
      v_r[3] <= v_r[2];
      v_r[2] <= rotl(v_r[1], 5'd9);
      v_r[1] <= v_r[0];
      v_r[0] <= tt1;
      v_r[7] <= v_r[6];
      v_r[6] <= rotl(v_r[5], 5'd19);
      v_r[5] <= v_r[4];
      v_r[4] <= perm0(tt2);
    end
  end

  // Chaining value.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_msg) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= SM3_IV[(7 - i) * 32 +: 32];
      end
    end else if (cmd.finish) begin
      cv_r[0] <= cv_r[0] ^ tt1;
      cv_r[1] <= cv_r[1] ^ v_r[0];
      cv_r[2] <= cv_r[2] ^ rotl(v_r[1], 5'd9);
      cv_r[3] <= cv_r[3] ^ v_r[2];
      cv_r[4] <= cv_r[4] ^ perm0(tt2);
      cv_r[5] <= cv_r[5] ^ v_r[4];
      cv_r[6] <= cv_r[6] ^ rotl(v_r[5], 5'd19);
      cv_r[7] <= cv_r[7] ^ v_r[6];
    end
  end

endmodule

>>> tb/sv/sm3_digest_checker.sv
// Checker for the SM3 hash engine: watches both channels, predicts digests and compares.
// Depends on sm3_pkg for the initial value and round constants.
module sm3_digest_checker import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_word_t;

  digest_word_t expected_words[$];
  logic [31:0]  chain_value[8];
  logic [7:0]   msg_block[64];
  logic [63:0]  bit_count;

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [31:0] mix0(input logic [31:0] x);
    return x ^ rot_left(x, 9) ^ rot_left(x, 17);
  endfunction

  function automatic logic [31:0] mix1(input logic [31:0] x);
    return x ^ rot_left(x, 15) ^ rot_left(x, 23);
  endfunction

  // Compress the current message block into the chaining value.
  task automatic compress_msg_block();
    logic [31:0] w[68];
    logic [31:0] v[8];
    logic [31:0] tj, ss1, ss2, tt1, tt2, ff, gg;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 68; i++)
      w[i] = mix1(w[i-16] ^ w[i-9] ^ rot_left(w[i-3], 15)) ^ rot_left(w[i-13], 7) ^ w[i-6];
    for (int i = 0; i < 8; i++) v[i] = chain_value[i];
    for (int j = 0; j < 64; j++) begin
      if (j < 16) begin
        tj = rot_left(T_LOW, j);
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        tj = rot_left(T_HIGH, j);
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      ss1 = rot_left(rot_left(v[0], 12) + v[4] + tj, 7);
      ss2 = ss1 ^ rot_left(v[0], 12);
      tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + v[7] + ss1 + w[j];
      v[3] = v[2];
      v[2] = rot_left(v[1], 9);
      v[1] = v[0];
      v[0] = tt1;
      v[7] = v[6];
      v[6] = rot_left(v[5], 19);
      v[5] = v[4];
      v[4] = mix0(tt2);
    end
    for (int i = 0; i < 8; i++) chain_value[i] ^= v[i];
  endtask

  // Apply one accepted request to the predicted state.
  task automatic absorb_request(input logic [7:0] data, input logic has_byte,
                                input logic ends_msg);
    int pos;
    logic [63:0] bits;
    digest_word_t dw;
    if (has_byte) begin
      pos = int'(bit_count[8:3]);
      msg_block[pos] = data;
      bit_count += 64'd8;
      if (pos == 63) compress_msg_block();
    end
    if (ends_msg) begin
      bits = bit_count;
      pos = int'(bits[8:3]);
      msg_block[pos] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) msg_block[i] = 8'h00;
        compress_msg_block();
        pos = 0;
      end
      for (int i = pos; i < 56; i++) msg_block[i] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
        dw.word = chain_value[i];
        dw.index = 3'(i);
        dw.final_word = (i == 7);
        expected_words.push_back(dw);
      end
      for (int i = 0; i < 8; i++) chain_value[i] = SM3_IV[255-32*i -: 32];
      bit_count = '0;
    end
  endtask

  assign pending_words = expected_words.size();

  // Predict on accepted requests and compare accepted results.
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      expected_words.delete();
      for (int i = 0; i < 8; i++) chain_value[i] = SM3_IV[255-32*i -: 32];
      bit_count = '0;
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) absorb_request(in_data_byte, in_byte_valid, in_last);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected digest word %h", out_digest_word);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_digest_word !== exp_w.word) begin
            $error("digest_word expected %h actual %h", exp_w.word, out_digest_word);
            fail_count++;
          end
          if (out_word_index !== exp_w.index) begin
            $error("word_index expected %0d actual %0d", exp_w.index, out_word_index);
            fail_count++;
          end
          if (out_last_word !== exp_w.final_word) begin
            $error("last_word expected %0d actual %0d", exp_w.final_word, out_last_word);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/sm3_hash_engine_tb.sv
// Testbench top for the SM3 hash engine: clock, reset, message stimulus and verdict.
// Depends on sm3_pkg, sm3_hash_engine and sm3_digest_checker.
module sm3_hash_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_valid = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          pending_words;
  int          items_sent = 0;
  bit          quiet_idle = 1'b0;
  bit          long_hold = 1'b0;

  sm3_hash_engine DUT (.*);
  sm3_digest_checker checker_inst (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Present one request and hold it until it is accepted.
  task automatic send_request(input logic [7:0] data, input logic has_byte,
                              input logic ends_msg);
    while (!quiet_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_byte_valid <= has_byte;
    in_last <= ends_msg;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // A whole message of random bytes with occasional no-byte items, sometimes ended by a bare marker.
  task automatic send_message(input int len);
    bit bare_end;
    bare_end = $urandom_range(1);
    if (len == 0) bare_end = 1;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stalls, except during a quiet stretch or a long hold-off.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) out_stall <= 1'b1;
      else out_stall <= !quiet_idle && ($urandom_range(99) < 9);
    end
  end

  initial begin
    int lens[6] = '{0, 1, 55, 56, 64, 3};
    int start_count;
    int waited;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed: extreme bytes, ignored no-byte items, short messages.
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hAA, 1'b0, 1'b0);
    send_request(8'h55, 1'b1, 1'b1);
    send_request(8'h80, 1'b1, 1'b1);
    // Boundary lengths around one and two padding blocks.
    foreach (lens[i]) send_message(lens[i]);
    // Long hold-off on the receiver while messages keep arriving.
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      begin
        send_message(3);
        send_message(5);
        send_message(2);
      end
    join
    // Random messages, mostly short, with one stretch free of idling.
    start_count = items_sent;
    while (items_sent < 260) begin
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
      if (len > 260 - items_sent) len = 260 - items_sent;
      quiet_idle = (items_sent - start_count >= 10) && (items_sent - start_count < 40);
      send_message(len);
    end
    in_valid <= 1'b0;
    quiet_idle = 1'b0;
    waited = 0;
    while (pending_words != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
